>>> src/pfsc_pkg.sv
// Shared types and constants for the pose frame sync checker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package pfsc_pkg;

    localparam int FRAME_BYTES = 46;
    localparam int HDR_BYTES   = 4;
    localparam int NUM_WORDS   = 10;
    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 6;
    localparam int DATA_W      = NUM_WORDS * WORD_W;

    localparam logic [WORD_W-1:0] SYNC_RESET = 32'h7FAA_AAAA;

    localparam logic [IDX_W-1:0] IDX_BODY_START = IDX_W'(HDR_BYTES);
    localparam logic [IDX_W-1:0] IDX_PAYLOAD_END = IDX_W'(FRAME_BYTES - 3);
    localparam logic [IDX_W-1:0] IDX_CSA = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] IDX_CSB = IDX_W'(FRAME_BYTES - 1);

    typedef enum logic [1:0] {
        MODE_HUNT = 2'd0,
        MODE_BODY = 2'd1,
        MODE_HEAD = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CSUM_ERR  = 2'd1,
        ST_SYNC_LOST = 2'd2
    } status_t;

    typedef struct packed {
        logic    payload_shift;
        logic    hunt_shift;
        logic    emit;
        status_t status;
    } ctrl_t;

endpackage

`default_nettype wire

>>> src/pose_frame_sync_checker.sv
// Top level of the pose frame sync checker: sync hunt cell, payload cell chain,
// framing sequencer and registered result stage. Depends on pfsc_pkg,
// pfsc_word_cell and pfsc_frame_ctrl.
//
// Takes one received byte per clock and searches the last four bytes, little-endian,
// for sync_word. After a match it collects a 46-byte frame: the 40 payload bytes
// shift through a row of ten 32-bit cells while an 8-bit Fletcher-style sum pair
// runs over them, and after the second checksum byte one result item is issued
// (status ok or checksum error, nine pose words and the timestamp). The next
// frame's header is checked; a mismatch issues a sync-lost item with zero data
// and the block resumes hunting. The result sits in an output register that reloads in
// the cycle it drains, so input bytes stall only while that register holds an item
// and m_tready is low. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none

module pose_frame_sync_checker
    import pfsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [DATA_W-1:0] m_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                                              // roll_bits, pitch_bits, yaw_bits,
                                              // timestamp; 32 bits each from bit 0
    output logic      [1:0]        m_tuser,   // [1:0] status
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [WORD_W-1:0] cfg_data   // [31:0] sync_word
);

    logic              step;
    logic [WORD_W-1:0] sync_word_reg;
    logic [WORD_W-1:0] sync_word_next;
    logic [WORD_W-1:0] hunt_word;
    logic [WORD_W-1:0] hunt_shifted;
    logic              hunt_match;
    logic [WORD_W-1:0] payload_word [NUM_WORDS];
    logic [DATA_W-1:0] frame_data;
    ctrl_t             ctrl;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic [1:0]        out_status_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;

    assign s_tready = !out_valid_reg || m_tready;
    assign step     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign hunt_shifted = {s_tdata, hunt_word[WORD_W-1:BYTE_W]};
    assign hunt_match   = (hunt_shifted == sync_word_reg);

    pfsc_word_cell u_hunt_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (ctrl.hunt_shift),
        .byte_in  (s_tdata),
        .word     (hunt_word)
    );

    genvar k;
    generate
        for (k = 0; k < NUM_WORDS; k++)
        begin : g_cell
            logic [BYTE_W-1:0] cell_byte_in;
            if (k == NUM_WORDS - 1)
            begin : g_head
                assign cell_byte_in = s_tdata;
            end
            else
            begin : g_link
                assign cell_byte_in = payload_word[k+1][BYTE_W-1:0];
            end
            pfsc_word_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (ctrl.payload_shift),
                .byte_in  (cell_byte_in),
                .word     (payload_word[k])
            );
            assign frame_data[k*WORD_W +: WORD_W] = payload_word[k];
        end
    endgenerate

    pfsc_frame_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (s_tdata),
        .hunt_match (hunt_match),
        .ctrl       (ctrl)
    );

    always_comb
    begin
        sync_word_next = sync_word_reg;
        if (cfg_valid)
        begin
            sync_word_next = cfg_data;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        if (step && ctrl.emit)
        begin
            out_valid_next  = 1'b1;
            out_status_next = ctrl.status;
            out_data_next   = (ctrl.status == ST_SYNC_LOST) ? '0 : frame_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg <= SYNC_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sync_word_reg <= sync_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

>>> src/pfsc_word_cell.sv
// One 32-bit byte-shift cell of the frame chain.
// Depends on pfsc_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module pfsc_word_cell
    import pfsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shift_en,
    input  wire logic [BYTE_W-1:0] byte_in,
    output logic      [WORD_W-1:0] word
);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (shift_en)
        begin
            word_next = {byte_in, word_reg[WORD_W-1:BYTE_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
        end
        else
        begin
            word_reg <= word_next;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

>>> src/pfsc_frame_ctrl.sv
// Framing sequencer: hunt/body/header modes, byte index and checksum sums.
// Depends on pfsc_pkg for mode, status and control types.
`timescale 1ns / 1ps
`default_nettype none

module pfsc_frame_ctrl
    import pfsc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              hunt_match,
    output ctrl_t                  ctrl
);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [BYTE_W-1:0] sum_a_reg;
    logic [BYTE_W-1:0] sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg;
    logic [BYTE_W-1:0] sum_b_next;
    logic [BYTE_W-1:0] sum_a_add;
    logic [IDX_W-1:0]  idx_inc;

    assign sum_a_add = sum_a_reg + rx_byte;
    assign idx_inc   = idx_reg + IDX_W'(1);

    always_comb
    begin
        mode_next          = mode_reg;
        idx_next           = idx_reg;
        sum_a_next         = sum_a_reg;
        sum_b_next         = sum_b_reg;
        ctrl.payload_shift = 1'b0;
        ctrl.hunt_shift    = 1'b0;
        ctrl.emit          = 1'b0;
        ctrl.status        = ST_OK;
        if (step)
        begin
            unique case (mode_reg)
                MODE_BODY:
                begin
                    if ((idx_reg >= IDX_BODY_START) && (idx_reg <= IDX_PAYLOAD_END))
                    begin
                        ctrl.payload_shift = 1'b1;
                        sum_a_next         = sum_a_add;
                        sum_b_next         = sum_b_reg + sum_a_add;
                        idx_next           = idx_inc;
                    end
                    else if (idx_reg == IDX_CSA)
                    begin
                        sum_a_next = sum_a_reg ^ rx_byte;
                        idx_next   = idx_inc;
                    end
                    else if (idx_reg == IDX_CSB)
                    begin
                        ctrl.emit   = 1'b1;
                        ctrl.status = ((sum_a_reg == '0) && (sum_b_reg == rx_byte))
                                      ? ST_OK : ST_CSUM_ERR;
                        mode_next   = MODE_HEAD;
                        idx_next    = '0;
                    end
                    else
                    begin
                        // stray index: restart the hunt
                        ctrl.hunt_shift = 1'b1;
                        mode_next       = MODE_HUNT;
                        idx_next        = '0;
                        if (hunt_match)
                        begin
                            mode_next  = MODE_BODY;
                            idx_next   = IDX_BODY_START;
                            sum_a_next = '0;
                            sum_b_next = '0;
                        end
                    end
                end
                MODE_HEAD:
                begin
                    ctrl.hunt_shift = 1'b1;
                    idx_next        = idx_inc;
                    if (idx_inc == IDX_BODY_START)
                    begin
                        if (hunt_match)
                        begin
                            mode_next  = MODE_BODY;
                            sum_a_next = '0;
                            sum_b_next = '0;
                        end
                        else
                        begin
                            mode_next   = MODE_HUNT;
                            idx_next    = '0;
                            ctrl.emit   = 1'b1;
                            ctrl.status = ST_SYNC_LOST;
                        end
                    end
                end
                default:
                begin
                    ctrl.hunt_shift = 1'b1;
                    mode_next       = MODE_HUNT;
                    if (hunt_match)
                    begin
                        mode_next  = MODE_BODY;
                        idx_next   = IDX_BODY_START;
                        sum_a_next = '0;
                        sum_b_next = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_HUNT;
            idx_reg   <= '0;
            sum_a_reg <= '0;
            sum_b_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            idx_reg   <= idx_next;
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

endmodule

`default_nettype wire

>>> src/pfsc_port_checker.sv
// Port-level checker for pose_frame_sync_checker, with its bind statement.
// Depends on pfsc_pkg for widths and status codes.
`timescale 1ns / 1ps
`default_nettype none

module pfsc_port_checker
    import pfsc_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic [1:0]        m_tuser
);

    property p_sync_lost_zero;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && (m_tuser == ST_SYNC_LOST)) |-> (m_tdata == '0);
    endproperty
    a_sync_lost_zero: assert property (p_sync_lost_zero)
        else $error("sync-lost item carries nonzero data");

    property p_ready_when_drained;
        @(posedge clk) disable iff (!rst_n)
            m_tready |-> s_tready;
    endproperty
    a_ready_when_drained: assert property (p_ready_when_drained)
        else $error("input stalled while output drains");

    property p_result_follows_input;
        @(posedge clk) disable iff (!rst_n)
            $rose(m_tvalid) |-> $past(s_tvalid && s_tready);
    endproperty
    a_result_follows_input: assert property (p_result_follows_input)
        else $error("result item without an accepted input item");

    property p_hold_stalled;
        @(posedge clk) disable iff (!rst_n)
            (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser));
    endproperty
    a_hold_stalled: assert property (p_hold_stalled)
        else $error("stalled output item changed");

endmodule

bind pose_frame_sync_checker pfsc_port_checker u_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
